[hdl/hcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_pkg: shared types, constants and tables of the height color ramp
// Holds the fixed-point format, the ramp break points, the color stops and
// the lane record that travels down the divider cell chains.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HEIGHT_W  = 16;
  localparam int MAX_W     = HEIGHT_W - 1;
  localparam int COLOR_W   = 8;
  localparam int EDGE_W    = FRAC_BITS + 1;
  localparam int DIV_W     = (FRAC_BITS - 1 > MAX_W) ? FRAC_BITS - 1 : MAX_W;
  localparam int SEG_W     = 3;

  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;

  localparam logic [EDGE_W-1:0] EDGE_0 = '0;
  localparam logic [EDGE_W-1:0] EDGE_1 = EDGE_W'((64'd2 * ONE_Q + 64'd10) / 64'd20);
  localparam logic [EDGE_W-1:0] EDGE_2 = EDGE_W'((64'd4 * ONE_Q + 64'd10) / 64'd20);
  localparam logic [EDGE_W-1:0] EDGE_3 = EDGE_W'((64'd7 * ONE_Q + 64'd10) / 64'd20);
  localparam logic [EDGE_W-1:0] EDGE_4 = EDGE_W'((64'd12 * ONE_Q + 64'd10) / 64'd20);
  localparam logic [EDGE_W-1:0] EDGE_5 = EDGE_W'((64'd16 * ONE_Q + 64'd10) / 64'd20);
  localparam logic [EDGE_W-1:0] EDGE_6 = EDGE_W'(ONE_Q);

  typedef enum logic [1:0] {
    KIND_RAMP,
    KIND_FLAT,
    KIND_LOW,
    KIND_HIGH
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEG_W-1:0] seg;
  } tag_t;

  typedef struct packed {
    logic                 valid;
    tag_t                 tag;
    logic [DIV_W-1:0]     rem;
    logic [DIV_W-1:0]     divisor;
    logic [FRAC_BITS-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  localparam rgb_t FLAT_COLOR = '{red: 8'd100, green: 8'd150, blue: 8'd100};

  localparam logic [SEG_W-1:0] LAST_STOP = 3'd6;

  function automatic logic [EDGE_W-1:0] seg_edge(input logic [SEG_W-1:0] k);
    logic [EDGE_W-1:0] e;
    unique case (k)
      3'd0:    e = EDGE_0;
      3'd1:    e = EDGE_1;
      3'd2:    e = EDGE_2;
      3'd3:    e = EDGE_3;
      3'd4:    e = EDGE_4;
      3'd5:    e = EDGE_5;
      default: e = EDGE_6;
    endcase
    return e;
  endfunction

  function automatic rgb_t stop_color(input logic [SEG_W-1:0] idx);
    rgb_t c;
    unique case (idx)
      3'd0:    c = '{red: 8'd20,  green: 8'd50,  blue: 8'd120};
      3'd1:    c = '{red: 8'd40,  green: 8'd80,  blue: 8'd180};
      3'd2:    c = '{red: 8'd194, green: 8'd178, blue: 8'd128};
      3'd3:    c = '{red: 8'd85,  green: 8'd140, blue: 8'd45};
      3'd4:    c = '{red: 8'd60,  green: 8'd100, blue: 8'd30};
      3'd5:    c = '{red: 8'd80,  green: 8'd70,  blue: 8'd60};
      3'd6:    c = '{red: 8'd240, green: 8'd245, blue: 8'd255};
      default: c = '{red: 8'd20,  green: 8'd50,  blue: 8'd120};
    endcase
    return c;
  endfunction

endpackage

[hdl/hcr_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_div_cell: one restoring-division cell
// Shifts the partial remainder, trial-subtracts the divisor and appends one
// quotient bit, then hands the lane to the next cell.
// ----------------------------------------------------------------------------
module hcr_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  hcr_pkg::div_lane_t lane_i,
  output hcr_pkg::div_lane_t lane_o
);
  import hcr_pkg::*;

  div_lane_t          lane_r;
  div_lane_t          lane_nxt;
  logic [DIV_W:0]     rem_sh;
  logic               fits;

  always_comb begin
    rem_sh   = {lane_i.rem, 1'b0};
    fits     = rem_sh >= {1'b0, lane_i.divisor};
    lane_nxt = lane_i;
    if (fits) begin
      lane_nxt.rem = DIV_W'(rem_sh - {1'b0, lane_i.divisor});
    end else begin
      lane_nxt.rem = rem_sh[DIV_W-1:0];
    end
    lane_nxt.quo = {lane_i.quo[FRAC_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (adv) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (adv) begin
      lane_r.tag     <= lane_nxt.tag;
      lane_r.rem     <= lane_nxt.rem;
      lane_r.divisor <= lane_nxt.divisor;
      lane_r.quo     <= lane_nxt.quo;
    end
  end

  assign lane_o = lane_r;

endmodule

[hdl/hcr_seg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_seg: ramp segment select
// Places the ratio among the break points and loads the offset into the
// segment and the segment width as the next division.
// ----------------------------------------------------------------------------
module hcr_seg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  hcr_pkg::div_lane_t lane_i,
  output hcr_pkg::div_lane_t lane_o
);
  import hcr_pkg::*;

  div_lane_t          lane_r;
  div_lane_t          lane_nxt;
  logic [EDGE_W-1:0]  ratio;
  logic [SEG_W-1:0]   seg;
  logic [EDGE_W-1:0]  lo;
  logic [EDGE_W-1:0]  hi;

  always_comb begin
    ratio = {1'b0, lane_i.quo};
    seg   = 3'd0;
    if (ratio >= EDGE_1) seg = 3'd1;
    if (ratio >= EDGE_2) seg = 3'd2;
    if (ratio >= EDGE_3) seg = 3'd3;
    if (ratio >= EDGE_4) seg = 3'd4;
    if (ratio >= EDGE_5) seg = 3'd5;
    lo = seg_edge(seg);
    hi = seg_edge(SEG_W'(seg + 3'd1));
    lane_nxt         = lane_i;
    lane_nxt.tag.seg = seg;
    lane_nxt.rem     = DIV_W'(ratio - lo);
    lane_nxt.divisor = DIV_W'(hi - lo);
    lane_nxt.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (adv) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (adv) begin
      lane_r.tag     <= lane_nxt.tag;
      lane_r.rem     <= lane_nxt.rem;
      lane_r.divisor <= lane_nxt.divisor;
      lane_r.quo     <= lane_nxt.quo;
    end
  end

  assign lane_o = lane_r;

endmodule

[hdl/hcr_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_blend: color blend stage
// Interpolates the two stop colors of the segment by the local fraction, or
// selects the fixed color for flat, clamped-low and clamped-high samples.
// ----------------------------------------------------------------------------
module hcr_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  hcr_pkg::div_lane_t lane_i,
  output logic               res_valid_o,
  output hcr_pkg::rgb_t      res_color_o
);
  import hcr_pkg::*;

  logic valid_r;
  rgb_t color_r;
  rgb_t color_nxt;
  rgb_t stop_a;
  rgb_t stop_b;

  function automatic logic [COLOR_W-1:0] mix(input logic [COLOR_W-1:0] a,
                                             input logic [COLOR_W-1:0] b,
                                             input logic [FRAC_BITS-1:0] t);
    logic signed [COLOR_W:0]           diff;
    logic signed [FRAC_BITS+COLOR_W+1:0] prod;
    logic signed [FRAC_BITS+COLOR_W+1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    sum  = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + prod;
    return sum[FRAC_BITS+COLOR_W-1:FRAC_BITS];
  endfunction

  always_comb begin
    stop_a = stop_color(lane_i.tag.seg);
    stop_b = stop_color(SEG_W'(lane_i.tag.seg + 3'd1));
    unique case (lane_i.tag.kind)
      KIND_FLAT: color_nxt = FLAT_COLOR;
      KIND_LOW:  color_nxt = stop_color(3'd0);
      KIND_HIGH: color_nxt = stop_color(LAST_STOP);
      default: begin
        color_nxt.red   = mix(stop_a.red,   stop_b.red,   lane_i.quo);
        color_nxt.green = mix(stop_a.green, stop_b.green, lane_i.quo);
        color_nxt.blue  = mix(stop_a.blue,  stop_b.blue,  lane_i.quo);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= lane_i.valid;
    end
    if (adv) begin
      color_r <= color_nxt;
    end
  end

  assign res_valid_o = valid_r;
  assign res_color_o = color_r;

endmodule

[hdl/height_color_ramp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_color_ramp: terrain height to RGB color ramp
// Maps a signed height sample to a seven-stop piecewise-linear color ramp.
// ----------------------------------------------------------------------------
// Takes one height sample per clock while in_stall is low and returns one
// color per sample, in order. The ratio height/max_height is formed by a
// chain of FRAC_BITS restoring-division cells, one quotient bit per cell;
// a segment-select stage follows, then a second chain of FRAC_BITS cells
// forms the local fraction, then a blend stage with one multiplier per
// channel. An output register plus one skid entry decouple the two sides;
// in_stall rises only once the skid entry is occupied. Write max_height
// only while no sample is in flight; zero gives flat green.
// ----------------------------------------------------------------------------
module height_color_ramp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [hcr_pkg::MAX_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hcr_pkg::HEIGHT_W-1:0] in_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hcr_pkg::COLOR_W-1:0]         out_red,
  output logic [hcr_pkg::COLOR_W-1:0]         out_green,
  output logic [hcr_pkg::COLOR_W-1:0]         out_blue
);
  import hcr_pkg::*;

  logic [MAX_W-1:0] max_height_r;
  logic             adv;
  div_lane_t        ratio_lane [0:FRAC_BITS];
  div_lane_t        frac_lane  [0:FRAC_BITS];
  logic             res_valid;
  rgb_t             res_color;
  logic             out_valid_r;
  logic             out_valid_nxt;
  rgb_t             out_color_r;
  rgb_t             out_color_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  rgb_t             skid_color_r;
  rgb_t             skid_color_nxt;
  logic             take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_height_r <= '0;
    end else if (cfg_wr_en) begin
      max_height_r <= cfg_wr_data;
    end
  end

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_comb begin
    ratio_lane[0].valid   = in_valid;
    ratio_lane[0].tag.seg = '0;
    ratio_lane[0].rem     = DIV_W'(in_height[HEIGHT_W-2:0]);
    ratio_lane[0].divisor = DIV_W'(max_height_r);
    ratio_lane[0].quo     = '0;
    if (max_height_r == '0) begin
      ratio_lane[0].tag.kind = KIND_FLAT;
    end else if (in_height[HEIGHT_W-1] || in_height == '0) begin
      ratio_lane[0].tag.kind = KIND_LOW;
    end else if (in_height[HEIGHT_W-2:0] >= max_height_r) begin
      ratio_lane[0].tag.kind = KIND_HIGH;
    end else begin
      ratio_lane[0].tag.kind = KIND_RAMP;
    end
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_ratio
    hcr_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .lane_i (ratio_lane[i]),
      .lane_o (ratio_lane[i+1])
    );
  end

  hcr_seg u_seg (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .lane_i (ratio_lane[FRAC_BITS]),
    .lane_o (frac_lane[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_frac
    hcr_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .lane_i (frac_lane[i]),
      .lane_o (frac_lane[i+1])
    );
  end

  hcr_blend u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .lane_i      (frac_lane[FRAC_BITS]),
    .res_valid_o (res_valid),
    .res_color_o (res_color)
  );

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_color_nxt  = out_color_r;
    skid_valid_nxt = skid_valid_r;
    skid_color_nxt = skid_color_r;
    if (adv && res_valid) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_color_nxt = res_color;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_color_nxt = res_color;
      end
    end else if (take) begin
      if (skid_valid_r) begin
        out_color_nxt  = skid_color_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_color_r  <= out_color_nxt;
    skid_color_r <= skid_color_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_color_r.red;
  assign out_green = out_color_r.green;
  assign out_blue  = out_color_r.blue;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall && res_valid))
    else $error("skid entry filled without a stalled output");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r)
    else $error("skid entry not drained on output transfer");
`endif

endmodule
